### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is low.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/lgs_pkg.sv
package lgs_pkg;

  localparam int MAX_STOPS_DEF = 8;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_SHADE = 2'd2;

  localparam logic [1:0] RES_PIXEL   = 2'd0;
  localparam logic [1:0] RES_ADDED   = 2'd1;
  localparam logic [1:0] RES_FULL    = 2'd2;
  localparam logic [1:0] RES_CLEARED = 2'd3;

  localparam logic [1:0] CFG_START_X = 2'd0;
  localparam logic [1:0] CFG_START_Y = 2'd1;
  localparam logic [1:0] CFG_END_X   = 2'd2;
  localparam logic [1:0] CFG_END_Y   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PROD_LEN,
    ST_PROD_DOT,
    ST_SUM,
    ST_DIV,
    ST_SCAN,
    ST_BLEND_MUL,
    ST_BLEND_DIV,
    ST_DONE
  } lgs_state_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic prod_len;
    logic prod_dot;
    logic sum;
    logic div_step;
    logic scan;
    logic bmul;
    logic bdiv;
    logic out_load;
  } lgs_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       cnt_lt2;
    logic       t_direct;
    logic       div_last;
    logic       scan_end;
    logic       scan_seg;
    logic       bdiv_last;
    logic       out_free;
  } lgs_stat_t;

endpackage

### rtl/core/lgs_ctrl.sv
module lgs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             ready,
  output lgs_pkg::lgs_cmd_t cmd,
  input  lgs_pkg::lgs_stat_t stat
);
  import lgs_pkg::*;

  lgs_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        case (stat.op)
          OP_CLEAR: state_next = ST_DONE;
          OP_ADD:   state_next = ST_DONE;
          OP_SHADE: state_next = stat.cnt_lt2 ? ST_DONE : ST_PROD_LEN;
          default:  state_next = ST_IDLE;
        endcase
      end
      ST_PROD_LEN:  state_next = ST_PROD_DOT;
      ST_PROD_DOT:  state_next = ST_SUM;
      ST_SUM:       state_next = stat.t_direct ? ST_SCAN : ST_DIV;
      ST_DIV: begin
        if (stat.div_last) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_end) state_next = ST_DONE;
        else if (stat.scan_seg) state_next = ST_BLEND_MUL;
      end
      ST_BLEND_MUL: state_next = ST_BLEND_DIV;
      ST_BLEND_DIV: begin
        if (stat.bdiv_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd   = '0;
    ready = 1'b0;
    case (state)
      ST_IDLE: begin
        ready    = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_DECODE:    cmd.decode   = 1'b1;
      ST_PROD_LEN:  cmd.prod_len = 1'b1;
      ST_PROD_DOT:  cmd.prod_dot = 1'b1;
      ST_SUM:       cmd.sum      = 1'b1;
      ST_DIV:       cmd.div_step = 1'b1;
      ST_SCAN:      cmd.scan     = 1'b1;
      ST_BLEND_MUL: cmd.bmul     = 1'b1;
      ST_BLEND_DIV: cmd.bdiv     = 1'b1;
      ST_DONE:      cmd.out_load = stat.out_free;
      default:      cmd = '0;
    endcase
  end

endmodule

### rtl/core/lgs_datapath.sv
module lgs_datapath #(
  parameter int MAX_STOPS = lgs_pkg::MAX_STOPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [87:0]        s_tdata,
  input  logic [1:0]         s_tuser,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [31:0]        m_tdata,
  output logic [1:0]         m_tuser,
  input  lgs_pkg::lgs_cmd_t  cmd,
  output lgs_pkg::lgs_stat_t stat
);
  import lgs_pkg::*;

  localparam int CW = $clog2(MAX_STOPS + 1);
  localparam int IW = $clog2(MAX_STOPS);

  logic signed [15:0] start_x, start_y, end_x, end_y;

  logic [1:0]         in_op;
  logic signed [17:0] in_pos;
  logic [3:0][7:0]    in_col;
  logic signed [15:0] in_px, in_py;

  logic signed [17:0] pos_tab [MAX_STOPS];
  logic [3:0][7:0]    col_tab [MAX_STOPS];
  logic [CW-1:0]      count;
  logic               full;
  logic [MAX_STOPS-1:0] gt;
  logic [MAX_STOPS-1:0] at_slot;
  logic               do_insert;

  logic signed [16:0] ax, ay, dx, dy;
  logic signed [33:0] prod_a, prod_b;
  logic [33:0]        len2;
  logic signed [34:0] dot_s;
  logic [34:0]        rem, rem_sh;
  logic               rem_ge;
  logic [15:0]        quo, quo_next;
  logic [3:0]         dcnt;
  logic [16:0]        t;
  logic signed [17:0] ts;

  logic [IW-1:0]      sidx;
  logic signed [17:0] cur_pos;
  logic [3:0][7:0]    cur_col;
  logic               is_last;
  logic signed [17:0] lo_pos, hi_pos;
  logic [3:0][7:0]    lo_col, hi_col;

  logic signed [18:0] span_d, k_d;
  logic [17:0]        span, kk;
  logic [25:0]        acc [4];
  logic [24:0]        dv;
  logic [2:0]         bcnt;

  logic [1:0]         res_status;
  logic [3:0][7:0]    res_col;
  logic [1:0]         out_status;
  logic [3:0][7:0]    out_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0;
      start_y <= '0;
      end_x   <= '0;
      end_y   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_X: start_x <= cfg_data;
        CFG_START_Y: start_y <= cfg_data;
        CFG_END_X:   end_x   <= cfg_data;
        CFG_END_Y:   end_y   <= cfg_data;
        default:     start_x <= start_x;
      endcase
    end
  end

  // stop table: sorted insert, later equal positions go after
  assign full      = (count == CW'(MAX_STOPS));
  assign do_insert = cmd.decode && (in_op == OP_ADD) && !full;

  always_comb begin
    for (int i = 0; i < MAX_STOPS; i++) begin
      gt[i]      = (CW'(i) < count) && (pos_tab[i] > in_pos);
      at_slot[i] = gt[i] || (CW'(i) == count);
    end
  end

  for (genvar g = 0; g < MAX_STOPS; g++) begin : g_ent
    if (g == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (do_insert && at_slot[g]) begin
          pos_tab[g] <= in_pos;
          col_tab[g] <= in_col;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (do_insert) begin
          if (gt[g-1]) begin
            pos_tab[g] <= pos_tab[g-1];
            col_tab[g] <= col_tab[g-1];
          end else if (at_slot[g]) begin
            pos_tab[g] <= in_pos;
            col_tab[g] <= in_col;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.decode && in_op == OP_CLEAR) begin
      count <= '0;
    end else if (do_insert) begin
      count <= count + CW'(1);
    end
  end

  // projection
  assign ax = $signed({end_x[15], end_x}) - $signed({start_x[15], start_x});
  assign ay = $signed({end_y[15], end_y}) - $signed({start_y[15], start_y});
  assign dx = $signed({in_px[15], in_px}) - $signed({start_x[15], start_x});
  assign dy = $signed({in_py[15], in_py}) - $signed({start_y[15], start_y});
  assign dot_s  = $signed({prod_a[33], prod_a}) + $signed({prod_b[33], prod_b});
  assign rem_sh = {rem[33:0], 1'b0};
  assign rem_ge = rem_sh >= {1'b0, len2};
  assign quo_next = {quo[14:0], rem_ge};
  assign ts = $signed({1'b0, t});

  // segment search
  assign cur_pos = pos_tab[sidx];
  assign cur_col = col_tab[sidx];
  assign is_last = (CW'(sidx) + CW'(1)) == count;

  // blend
  assign span_d = $signed({hi_pos[17], hi_pos}) - $signed({lo_pos[17], lo_pos});
  assign k_d    = $signed({ts[17], ts}) - $signed({lo_pos[17], lo_pos});
  assign span   = span_d[17:0];
  assign kk     = k_d[17:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_op  <= s_tuser;
      in_pos <= s_tdata[17:0];
      in_col <= s_tdata[49:18];
      in_px  <= s_tdata[65:50];
      in_py  <= s_tdata[81:66];
    end
    if (cmd.decode) begin
      res_col <= '0;
      case (in_op)
        OP_CLEAR: res_status <= RES_CLEARED;
        OP_ADD:   res_status <= full ? RES_FULL : RES_ADDED;
        default: begin
          res_status <= RES_PIXEL;
          if (count == '0) res_col <= {4{8'hFF}};
          else             res_col <= col_tab[0];
        end
      endcase
    end
    if (cmd.prod_len) begin
      prod_a <= ax * ax;
      prod_b <= ay * ay;
    end
    if (cmd.prod_dot) begin
      len2   <= $unsigned(prod_a) + $unsigned(prod_b);
      prod_a <= dx * ax;
      prod_b <= dy * ay;
    end
    if (cmd.sum) begin
      sidx <= '0;
      rem  <= {1'b0, dot_s[33:0]};
      quo  <= '0;
      dcnt <= '0;
      if (len2 == '0 || dot_s <= 0) t <= '0;
      else                          t <= 17'h10000;
    end
    if (cmd.div_step) begin
      rem  <= rem_ge ? (rem_sh - {1'b0, len2}) : rem_sh;
      quo  <= quo_next;
      dcnt <= dcnt + 4'd1;
      t    <= {1'b0, quo_next};
    end
    if (cmd.scan) begin
      if (stat.scan_end) begin
        res_col <= cur_col;
      end else if (stat.scan_seg) begin
        hi_pos <= cur_pos;
        hi_col <= cur_col;
      end else begin
        lo_pos <= cur_pos;
        lo_col <= cur_col;
        sidx   <= sidx + IW'(1);
      end
    end
    if (cmd.bmul) begin
      for (int c = 0; c < 4; c++) begin
        acc[c] <= 26'(lo_col[c]) * 26'(span - kk) + 26'(hi_col[c]) * 26'(kk)
                  + 26'(span[17:1]);
      end
      dv      <= {span, 7'b0};
      bcnt    <= '0;
      res_col <= '0;
    end
    if (cmd.bdiv) begin
      for (int c = 0; c < 4; c++) begin
        if (acc[c] >= {1'b0, dv}) begin
          acc[c]     <= acc[c] - {1'b0, dv};
          res_col[c] <= {res_col[c][6:0], 1'b1};
        end else begin
          res_col[c] <= {res_col[c][6:0], 1'b0};
        end
      end
      dv   <= dv >> 1;
      bcnt <= bcnt + 3'd1;
    end
    if (cmd.out_load) begin
      out_status <= res_status;
      out_col    <= res_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = out_col;
  assign m_tuser = out_status;

  always_comb begin
    stat.op        = in_op;
    stat.cnt_lt2   = count < CW'(2);
    stat.t_direct  = (len2 == '0) || (dot_s <= 0) || (dot_s >= $signed({1'b0, len2}));
    stat.div_last  = dcnt == 4'd15;
    stat.scan_end  = (sidx == '0) ? (ts <= cur_pos) : (!(cur_pos > ts) && is_last);
    stat.scan_seg  = (sidx != '0) && (cur_pos > ts);
    stat.bdiv_last = bcnt == 3'd7;
    stat.out_free  = !m_tvalid || m_tready;
  end

endmodule

### rtl/core/linear_gradient_shader.sv
// Linear gradient shader.
// Input stream (s_*): tuser carries the op (clear table, add stop, shade pixel),
// tdata the stop position and color and the pixel coordinate. Every op but the
// unused code returns one result on the output stream (m_*): tuser the status,
// tdata the RGBA color. The axis registers are to be written on the cfg port
// only while idle; the block itself leaves this to the user. One item is
// processed at a time; s_tready is high only while idle.
// Clear, add, and shade with fewer than two stops skip the projection.
// Other shades run the serial divide only when the projected point lies
// strictly between the axis ends, and blend only when t falls inside the
// stops; the segment search visits 1..MAX_STOPS stops. The projection
// divider has 16 steps and the channel dividers have 8 steps.
// The result sits in an output register; when the receiver stalls the block
// holds it, and a new item waits in the done state until it is transferred.
// Reset empties the stop table and zeroes the axis registers.
module linear_gradient_shader #(
  parameter int MAX_STOPS = lgs_pkg::MAX_STOPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // stop_position[17:0] red[25:18] green[33:26] blue[41:34] alpha[49:42]
  // pixel_x[65:50] pixel_y[81:66], zero pad
  input  logic [87:0] s_tdata,
  // op[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // red[7:0] green[15:8] blue[23:16] alpha[31:24]
  output logic [31:0] m_tdata,
  // status[1:0]
  output logic [1:0]  m_tuser
);
  import lgs_pkg::*;

  lgs_cmd_t  cmd;
  lgs_stat_t stat;

  lgs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .ready    (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  lgs_datapath #(.MAX_STOPS(MAX_STOPS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

`include "assert_macros.svh"

  `ASSERT_CLK(a_busy_after_accept, clk, rst, (s_tvalid && s_tready) |=> !s_tready, "ready after transfer")
  `ASSERT_CLK(a_load_when_free, clk, rst, cmd.out_load |-> stat.out_free, "result overwritten")
  `ASSERT_ALWAYS(a_one_cmd, clk, $onehot0(cmd), "several commands at once")
  `ASSERT_CLK(a_valid_after_load, clk, rst, cmd.out_load |=> m_tvalid, "result not shown")

endmodule
